@@ design/jsp_pkg.sv @@
// Shared types, constants and helpers for the joystick servo pulse controller.
`timescale 1ns / 1ps

package jsp_pkg;

  localparam int SHORT_TICKS_DEF = 125;
  localparam int FRAME_TICKS_DEF = 130;
  localparam int CHANNELS_DEF    = 4;

  localparam int SMP_W   = 10;
  localparam int ANGLE_W = 8;
  localparam int PULSE_W = 8;
  localparam int CNT_W   = 8;
  localparam int PIN_N   = 4;
  localparam int CH_W    = 2;

  localparam logic [SMP_W-1:0]   HIGH_THR_RST = 10'd700;
  localparam logic [SMP_W-1:0]   LOW_THR_RST  = 10'd300;
  localparam logic [ANGLE_W-1:0] FINE_RST     = 8'd1;
  localparam logic [ANGLE_W-1:0] COARSE_RST   = 8'd3;

  localparam logic [ANGLE_W-1:0] ANGLE_RST     = 8'd120;
  localparam logic [ANGLE_W-1:0] ANGLE_RST_CH3 = 8'd30;

  // floor(a*5/9) == (a*36410) >> 16 for every 8-bit a
  localparam logic [16:0]        PULSE_RECIP  = 17'd36410;
  localparam logic [PULSE_W-1:0] PULSE_OFFSET = 8'd25;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_ADJUST = 2'd1,
    OP_TICK   = 2'd2,
    OP_NONE   = 2'd3
  } jsp_op_t;

  typedef enum logic [1:0] {
    REG_HIGH_THR = 2'd0,
    REG_LOW_THR  = 2'd1,
    REG_FINE     = 2'd2,
    REG_COARSE   = 2'd3
  } jsp_reg_t;

  typedef struct packed {
    logic [SMP_W-1:0]   high_thr;
    logic [SMP_W-1:0]   low_thr;
    logic [ANGLE_W-1:0] fine_step;
    logic [ANGLE_W-1:0] coarse_step;
  } jsp_cfg_t;

  typedef struct packed {
    logic [PIN_N-1:0] pins;
    logic             long_interval;
  } jsp_res_t;

  function automatic logic [PULSE_W-1:0] to_pulse(input logic [ANGLE_W-1:0] angle);
    logic [23:0] prod;
    prod = {16'd0, angle} * {7'd0, PULSE_RECIP};
    return prod[23:16] + PULSE_OFFSET;
  endfunction

endpackage

@@ design/jsp_cfg.sv @@
// APB-style configuration register file.
`timescale 1ns / 1ps

module jsp_cfg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output jsp_pkg::jsp_cfg_t   cfg
);
  import jsp_pkg::*;

  jsp_cfg_t cfg_r;
  jsp_cfg_t cfg_nxt;
  jsp_reg_t idx;
  logic     wr_en;

  assign idx   = jsp_reg_t'(paddr[3:2]);
  assign wr_en = psel && penable && pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_HIGH_THR: cfg_nxt.high_thr    = pwdata[SMP_W-1:0];
        REG_LOW_THR:  cfg_nxt.low_thr     = pwdata[SMP_W-1:0];
        REG_FINE:     cfg_nxt.fine_step   = pwdata[ANGLE_W-1:0];
        REG_COARSE:   cfg_nxt.coarse_step = pwdata[ANGLE_W-1:0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.high_thr    <= HIGH_THR_RST;
      cfg_r.low_thr     <= LOW_THR_RST;
      cfg_r.fine_step   <= FINE_RST;
      cfg_r.coarse_step <= COARSE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (idx)
      REG_HIGH_THR: prdata = {22'd0, cfg_r.high_thr};
      REG_LOW_THR:  prdata = {22'd0, cfg_r.low_thr};
      REG_FINE:     prdata = {24'd0, cfg_r.fine_step};
      REG_COARSE:   prdata = {24'd0, cfg_r.coarse_step};
      default:      prdata = 32'd0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

@@ design/jsp_core.sv @@
// Channel state (samples, angles, pulse values, frame counter, pins) and its update.
`timescale 1ns / 1ps

module jsp_core #(
  parameter int SHORT_TICKS = jsp_pkg::SHORT_TICKS_DEF,
  parameter int FRAME_TICKS = jsp_pkg::FRAME_TICKS_DEF,
  parameter int CHANNELS    = jsp_pkg::CHANNELS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      step,
  input  jsp_pkg::jsp_op_t          op,
  input  logic [jsp_pkg::CH_W-1:0]  ch,
  input  logic [jsp_pkg::SMP_W-1:0] smp,
  input  jsp_pkg::jsp_cfg_t         cfg,
  output jsp_pkg::jsp_res_t         res
);
  import jsp_pkg::*;

  localparam logic [CNT_W-1:0] SHORT_C = CNT_W'(SHORT_TICKS);
  localparam logic [CNT_W-1:0] FRAME_C = CNT_W'(FRAME_TICKS);

  logic [SMP_W-1:0]   smp_r   [CHANNELS];
  logic [SMP_W-1:0]   smp_nxt [CHANNELS];
  logic [ANGLE_W-1:0] ang_r   [CHANNELS];
  logic [ANGLE_W-1:0] ang_nxt [CHANNELS];
  logic [PULSE_W-1:0] pv_r    [CHANNELS];
  logic [PULSE_W-1:0] pv_nxt  [CHANNELS];
  logic [CNT_W-1:0]   cnt_r, cnt_nxt, cnt_inc;
  logic [PIN_N-1:0]   pins_r, pins_nxt;

  always_comb begin
    logic [ANGLE_W-1:0] stp;
    logic [ANGLE_W-1:0] a;
    for (int i = 0; i < CHANNELS; i++) begin
      smp_nxt[i] = smp_r[i];
      ang_nxt[i] = ang_r[i];
      pv_nxt[i]  = pv_r[i];
    end
    cnt_nxt  = cnt_r;
    pins_nxt = pins_r;
    cnt_inc  = cnt_r + 8'd1;
    stp      = '0;
    a        = '0;
    case (op)
      OP_SAMPLE: begin
        for (int i = 0; i < CHANNELS; i++) begin
          if (int'(ch) == i) smp_nxt[i] = smp;
        end
      end
      OP_ADJUST: begin
        for (int i = 0; i < CHANNELS; i++) begin
          stp = (i < 2) ? cfg.fine_step : cfg.coarse_step;
          a   = ang_r[i];
          if (smp_r[i] > cfg.high_thr) a = ang_r[i] - stp;
          else if (smp_r[i] < cfg.low_thr) a = ang_r[i] + stp;
          ang_nxt[i] = a;
          pv_nxt[i]  = to_pulse(a);
        end
      end
      OP_TICK: begin
        cnt_nxt = cnt_inc;
        for (int i = 0; i < PIN_N && i < CHANNELS; i++) begin
          if (cnt_inc == pv_r[i]) pins_nxt[i] = 1'b0;
        end
        if (cnt_inc >= SHORT_C) pins_nxt = '1;
        if (cnt_inc == FRAME_C) begin
          pins_nxt = '1;
          cnt_nxt  = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        smp_r[i] <= '0;
        ang_r[i] <= (i == 3) ? ANGLE_RST_CH3 : ANGLE_RST;
        pv_r[i]  <= '0;
      end
      cnt_r  <= '0;
      pins_r <= '0;
    end else if (step) begin
      for (int i = 0; i < CHANNELS; i++) begin
        smp_r[i] <= smp_nxt[i];
        ang_r[i] <= ang_nxt[i];
        pv_r[i]  <= pv_nxt[i];
      end
      cnt_r  <= cnt_nxt;
      pins_r <= pins_nxt;
    end
  end

  assign res.pins          = pins_nxt;
  assign res.long_interval = (cnt_nxt >= SHORT_C);

endmodule

@@ design/joystick_servo_pwm_controller.sv @@
// Top level: input register, channel state update, result register, config port.
//
//  channel  | role   | payload
//  in_*     | slave  | tdata {sample[11:2], channel[1:0]}, tuser opcode[1:0]
//  out_*    | master | tdata {long_interval[4], pins[3:0]}
//  cfg_*    | APB    | 4 registers at 0x0, 0x4, 0x8, 0xC
//
// One item per cycle sustained while out_tready is high; an accepted item
// waits in the input register until its result is registered at the output.
// State is updated as an item moves from the input register to the result register.
// A stalled result holds; the input register still takes one more item behind it.
// Synchronous active-low reset; no clearing pass.
`timescale 1ns / 1ps

module joystick_servo_pwm_controller #(
  parameter int SHORT_TICKS = jsp_pkg::SHORT_TICKS_DEF,
  parameter int FRAME_TICKS = jsp_pkg::FRAME_TICKS_DEF,
  parameter int CHANNELS    = jsp_pkg::CHANNELS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // channel[1:0], sample[11:2], zero[15:12]
  input  logic [1:0]  in_tuser,   // opcode[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // pins[3:0], long_interval[4], zero[7:5]
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import jsp_pkg::*;

  jsp_cfg_t         cfg;
  jsp_res_t         res;

  logic             s1_valid_r, s1_valid_nxt;
  jsp_op_t          s1_op_r;
  logic [CH_W-1:0]  s1_ch_r;
  logic [SMP_W-1:0] s1_smp_r;
  logic             out_valid_r, out_valid_nxt;
  jsp_res_t         out_res_r;
  logic             adv;
  logic             in_acc;

  assign adv       = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || adv;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) s1_valid_nxt = 1'b1;
    else if (adv) s1_valid_nxt = 1'b0;
    out_valid_nxt = out_valid_r;
    if (adv) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r  <= jsp_op_t'(in_tuser);
      s1_ch_r  <= in_tdata[1:0];
      s1_smp_r <= in_tdata[11:2];
    end
    if (adv) out_res_r <= res;
  end

  jsp_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  jsp_core #(
    .SHORT_TICKS (SHORT_TICKS),
    .FRAME_TICKS (FRAME_TICKS),
    .CHANNELS    (CHANNELS)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (adv),
    .op    (s1_op_r),
    .ch    (s1_ch_r),
    .smp   (s1_smp_r),
    .cfg   (cfg),
    .res   (res)
  );

  assign cfg_pready = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'd0, out_res_r.long_interval, out_res_r.pins};

endmodule

@@ tb/testbench.sv @@
// Testbench for the joystick servo pulse controller: predicts each result and checks it.
`timescale 1ns / 1ps

module testbench;
  import jsp_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // channel[1:0], sample[11:2], zero[15:12]
  logic [1:0]  in_tuser;   // opcode[1:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;  // pins[3:0], long_interval[4], zero[7:5]
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  joystick_servo_pwm_controller dut (.*);

  // Predicted device state
  logic [SMP_W-1:0]   thr_high, thr_low;
  logic [ANGLE_W-1:0] step_fine, step_coarse;
  logic [SMP_W-1:0]   stick_reading [PIN_N];
  logic [ANGLE_W-1:0] servo_angle   [PIN_N];
  logic [PULSE_W-1:0] pulse_width   [PIN_N];
  logic [CNT_W-1:0]   frame_tick;
  logic [PIN_N-1:0]   pin_state;

  jsp_res_t pending_levels[$];
  int       fail_count = 0;
  bit       quiet = 1'b0;
  int       hold_req = 0;
  int       ready_wait = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic void reset_servo_model();
    thr_high    = HIGH_THR_RST;
    thr_low     = LOW_THR_RST;
    step_fine   = FINE_RST;
    step_coarse = COARSE_RST;
    for (int i = 0; i < PIN_N; i++) begin
      stick_reading[i] = '0;
      servo_angle[i]   = (i == 3) ? ANGLE_RST_CH3 : ANGLE_RST;
      pulse_width[i]   = '0;
    end
    frame_tick = '0;
    pin_state  = '0;
  endfunction

  function automatic void servo_model_step(jsp_op_t op, logic [1:0] ch, logic [9:0] smp);
    logic [ANGLE_W-1:0] step;
    jsp_res_t           r;
    case (op)
      OP_SAMPLE: begin
        if (ch < CHANNELS_DEF) stick_reading[ch] = smp;
      end
      OP_ADJUST: begin
        for (int i = 0; i < PIN_N; i++) begin
          step = (i < 2) ? step_fine : step_coarse;
          if (stick_reading[i] > thr_high) servo_angle[i] = servo_angle[i] - step;
          else if (stick_reading[i] < thr_low) servo_angle[i] = servo_angle[i] + step;
          pulse_width[i] = 8'((int'(servo_angle[i]) * 5) / 9 + 25);
        end
      end
      OP_TICK: begin
        frame_tick = frame_tick + 8'd1;
        for (int i = 0; i < PIN_N; i++) begin
          if (frame_tick == pulse_width[i]) pin_state[i] = 1'b0;
        end
        if (frame_tick >= SHORT_TICKS_DEF) pin_state = '1;
        if (frame_tick == FRAME_TICKS_DEF) begin
          pin_state  = '1;
          frame_tick = '0;
        end
      end
      default: ;
    endcase
    r.pins          = pin_state;
    r.long_interval = (frame_tick >= SHORT_TICKS_DEF);
    pending_levels.push_back(r);
  endfunction

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic logic [9:0] pick_sample();
    int r;
    r = $urandom_range(99);
    if (r < 15) return 10'd0;
    if (r < 30) return 10'd1023;
    if (r < 40) return 10'(thr_high + $urandom_range(2) - 1);
    if (r < 50) return 10'(thr_low + $urandom_range(2) - 1);
    return 10'($urandom_range(1023));
  endfunction

  // Result side: random back-pressure, with forced long hold-offs
  always @(negedge clk) begin : out_ready_drive
    int gap;
    if (hold_req > 0) begin
      ready_wait = hold_req;
      hold_req   = 0;
    end
    if (ready_wait > 0) begin
      out_tready <= 1'b0;
      ready_wait--;
    end else if (quiet) begin
      out_tready <= 1'b1;
    end else begin
      gap = pick_gap();
      if (gap == 0) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b0;
        ready_wait = gap - 1;
      end
    end
  end

  always @(posedge clk) begin : check_out
    jsp_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_levels.size() == 0) begin
        $display("%0t: unexpected item, actual %h", $time, out_tdata);
        fail_count++;
      end else begin
        want = pending_levels.pop_front();
        if (out_tdata[3:0] !== want.pins) begin
          $display("%0t: pins expected %h actual %h", $time, want.pins, out_tdata[3:0]);
          fail_count++;
        end
        if (out_tdata[4] !== want.long_interval) begin
          $display("%0t: long_interval expected %b actual %b", $time,
                   want.long_interval, out_tdata[4]);
          fail_count++;
        end
      end
    end
  end

  task automatic send_item(input jsp_op_t op, input logic [1:0] ch, input logic [9:0] smp);
    int gap;
    gap = quiet ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {4'd0, smp, ch};
    do @(posedge clk); while (!in_tready);
    servo_model_step(op, ch, smp);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input jsp_reg_t idx, input logic [31:0] val);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      REG_HIGH_THR: thr_high    = val[SMP_W-1:0];
      REG_LOW_THR:  thr_low     = val[SMP_W-1:0];
      REG_FINE:     step_fine   = val[ANGLE_W-1:0];
      REG_COARSE:   step_coarse = val[ANGLE_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic set_config(input int hi, input int lo, input int fine, input int coarse);
    wait_idle();
    write_reg(REG_HIGH_THR, hi);
    write_reg(REG_LOW_THR, lo);
    write_reg(REG_FINE, fine);
    write_reg(REG_COARSE, coarse);
  endtask

  task automatic test_reset_defaults();
    send_item(OP_TICK, 2'd0, 10'd0);
    send_item(OP_TICK, 2'd3, 10'd1023);
    send_item(OP_NONE, 2'd3, 10'd1023);
    send_item(OP_SAMPLE, 2'd0, 10'd1023);
    send_item(OP_SAMPLE, 2'd1, 10'd0);
    send_item(OP_SAMPLE, 2'd2, 10'd700);
    send_item(OP_SAMPLE, 2'd3, 10'd299);
    send_item(OP_ADJUST, 2'd0, 10'd0);
    send_item(OP_TICK, 2'd0, 10'd0);
    send_item(OP_NONE, 2'd0, 10'd0);
  endtask

  task automatic test_overlap_and_zero_step();
    set_config(100, 900, 0, 255);
    send_item(OP_SAMPLE, 2'd0, 10'd500);
    send_item(OP_SAMPLE, 2'd2, 10'd500);
    send_item(OP_SAMPLE, 2'd3, 10'd950);
    send_item(OP_ADJUST, 2'd1, 10'd512);
    send_item(OP_TICK, 2'd2, 10'd341);
    set_config(1023, 0, 255, 0);
    send_item(OP_ADJUST, 2'd0, 10'd0);
    send_item(OP_TICK, 2'd0, 10'd0);
  endtask

  task automatic test_random_traffic(input int count, input bit calm);
    int      r;
    jsp_op_t op;
    quiet = calm;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      if (r < 62) op = OP_TICK;
      else if (r < 80) op = OP_SAMPLE;
      else if (r < 95) op = OP_ADJUST;
      else op = OP_NONE;
      send_item(op, 2'($urandom_range(3)), (op == OP_SAMPLE) ? pick_sample()
                                                             : 10'($urandom_range(1023)));
    end
    quiet = 1'b0;
  endtask

  task automatic test_backpressure();
    wait_idle();
    quiet    = 1'b1;
    hold_req = 150;
    for (int n = 0; n < 40; n++) begin
      send_item(jsp_op_t'($urandom_range(3)), 2'($urandom_range(3)),
                10'($urandom_range(1023)));
    end
    quiet = 1'b0;
  endtask

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = OP_NONE;
    out_tready  = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    reset_servo_model();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_overlap_and_zero_step();
    set_config(700, 300, 1, 3);
    test_random_traffic(450, 1'b0);
    test_random_traffic(150, 1'b1);
    test_backpressure();
    set_config($urandom_range(1023), $urandom_range(1023),
               $urandom_range(255), $urandom_range(255));
    test_random_traffic(450, 1'b0);
    set_config(0, 1023, 255, 255);
    test_random_traffic(300, 1'b0);
    set_config(1023, 0, 0, 0);
    test_random_traffic(100, 1'b0);
    set_config($urandom_range(1023), $urandom_range(1023),
               $urandom_range(15), $urandom_range(15));
    test_random_traffic(550, 1'b0);

    wait_idle();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("joystick_servo_pwm_controller: match");
    end else begin
      $display("joystick_servo_pwm_controller: mismatch");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("joystick_servo_pwm_controller: mismatch");
    $finish;
  end

endmodule
